FILE: sv/bfa_pkg.sv
// Package for the best-fit allocator: status codes, opcodes and size constants.
// No dependencies; used by the allocator core and its testbench.
`timescale 1ns / 1ps
package bfa_pkg;
   localparam int unsigned HDR_BYTES = 16;
   localparam logic [16:0] SAT17 = 17'h1FFFF;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFIT  = 2'd1,
      ST_FULL   = 2'd2,
      ST_NULL   = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;
endpackage

FILE: sv/bfa_size_store.sv
// Header store: the granted block size for each 16-byte slot.
// Depends on nothing but the clock; read data is registered.
`timescale 1ns / 1ps
module bfa_size_store #(
   parameter int unsigned DEPTH = 4096,
   parameter int unsigned AW = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [16:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [16:0]   rd_data
);
   logic [16:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/bfa_core.sv
// Best-fit free-list allocator top level. Uses bfa_pkg and bfa_size_store.
// One request at a time: the next request is taken only once the block is back in idle after
// the response transfer. The search and the statistics scan read one table entry a cycle.
// Reset (synchronous, active high) restores one free block of MAX_REGION_BYTES, at most 65536,
// in the first idle cycle.
`timescale 1ns / 1ps
module best_fit_free_list_allocator_core
   import bfa_pkg::*;
#(
   parameter int unsigned MAX_REGION_BYTES = 65536,
   parameter int unsigned MAX_FREE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_payload_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_granted_offset,
   output logic [16:0] rsp_granted_bytes,
   output logic [16:0] rsp_free_total,
   output logic [16:0] rsp_fragmented_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_region_bytes
);
   localparam int unsigned SLOTS = MAX_REGION_BYTES / HDR_BYTES;
   localparam int unsigned SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned EAW   = $clog2(MAX_FREE_ENTRIES);
   localparam int unsigned CW    = $clog2(MAX_FREE_ENTRIES + 1);
   localparam int unsigned TW    = 17 + CW;
   localparam int unsigned HI_REGION = (MAX_REGION_BYTES < 65536) ? MAX_REGION_BYTES : 65536;
   localparam logic [16:0] HI17 = 17'(HI_REGION);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FREE_ENTRIES);

   // Sequencer states, one-hot.
   typedef enum logic [10:0] {
      S_IDLE   = 11'b00000000001,
      S_SRCH   = 11'b00000000010,  // read entry i, compare previous read
      S_DEC    = 11'b00000000100,  // decide split or remove
      S_RMRD   = 11'b00000001000,  // removal shift: read i+1
      S_RMWR   = 11'b00000010000,  // removal shift: write i
      S_FRRD   = 11'b00000100000,  // free: read size store, shift read i-1
      S_FRWR   = 11'b00001000000,  // free shift: write i
      S_FRHD   = 11'b00010000000,  // free: write head
      S_STAT   = 11'b00100000000,  // statistics scan
      S_DONE   = 11'b01000000000,
      S_RSP    = 11'b10000000000
   } state_type;

   state_type   state_ff, state_in;
   // Free table: one memory, entries are {offset, size}.
   logic [32:0] tbl [MAX_FREE_ENTRIES];
   logic [32:0] rd_ff;
   logic        tw_en;
   logic [EAW-1:0] tw_addr, tr_addr;
   logic [32:0] tw_data;

   logic [16:0] region_ff, region_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // current address issued
   logic        rdv_ff, rdv_in;       // rd_ff holds entry idx_ff-1
   logic [16:0] need_ff, need_in;
   logic        found_ff, found_in;
   logic [EAW-1:0] best_ff, best_in;
   logic [32:0] bent_ff, bent_in;
   // The running total is kept wide so that the fragmented figure is taken from the
   // true sum; both figures saturate only at the outputs.
   logic [TW-1:0] total_ff, total_in;
   logic [16:0] large_ff, large_in;
   logic [1:0]  st_ff, st_in;
   logic [15:0] goff_ff, goff_in;
   logic [16:0] gbytes_ff, gbytes_in;
   logic [15:0] blk_ff, blk_in;
   logic        init_ff, init_in;    // table needs its single entry rewritten

   logic        sw_en;
   logic [SAW-1:0] s_waddr, s_raddr;
   logic [16:0] s_wdata, s_rdata;

   bfa_size_store #(.DEPTH(SLOTS), .AW(SAW)) u_store (
      .clock(clock), .wr_en(sw_en), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   always_ff @(posedge clock) begin
      if (tw_en) begin
         tbl[tw_addr] <= tw_data;
      end
      rd_ff <= tbl[tr_addr];
   end

   logic [16:0] csr_clamped;
   logic [TW-1:0] sum_tw;
   logic [TW-1:0] frag_tw;
   logic [16:0] rd_size;
   logic [15:0] rd_off;

   always_comb begin
      csr_clamped = csr_region_bytes;
      if (csr_clamped < 17'd32) csr_clamped = 17'd32;
      if (csr_clamped > HI17)   csr_clamped = HI17;
      rd_size = rd_ff[16:0];
      rd_off  = rd_ff[32:17];
      sum_tw  = total_ff + TW'(rd_size);
      frag_tw = total_ff - TW'(large_ff);
   end

   // A region write takes precedence over a request, so the request side is held
   // off while one is offered.
   assign req_ready = (state_ff == S_IDLE) && !init_ff && !csr_valid;
   assign csr_ready = (state_ff == S_IDLE) && !init_ff;
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_status = st_ff;
   assign rsp_granted_offset = goff_ff;
   assign rsp_granted_bytes = gbytes_ff;
   assign rsp_free_total = (total_ff > TW'(SAT17)) ? SAT17 : total_ff[16:0];
   assign rsp_fragmented_bytes = (frag_tw > TW'(SAT17)) ? SAT17 : frag_tw[16:0];

   always_comb begin
      state_in = state_ff; region_in = region_ff; count_in = count_ff;
      idx_in = idx_ff; rdv_in = 1'b0; need_in = need_ff; found_in = found_ff;
      best_in = best_ff; bent_in = bent_ff; total_in = total_ff;
      large_in = large_ff; st_in = st_ff; goff_in = goff_ff;
      gbytes_in = gbytes_ff; blk_in = blk_ff; init_in = init_ff;
      tw_en = 1'b0; tw_addr = '0; tw_data = '0; tr_addr = idx_ff[EAW-1:0];
      sw_en = 1'b0; s_waddr = '0; s_wdata = '0;
      s_raddr = SAW'(blk_ff >> 4);
      unique case (state_ff)
         S_IDLE: begin
            if (init_ff) begin
               tw_en = 1'b1; tw_addr = '0; tw_data = {16'd0, region_ff};
               init_in = 1'b0; count_in = CW'(1);
            end else if (csr_valid) begin
               region_in = csr_clamped; init_in = 1'b1;
            end else if (req_valid) begin
               st_in = ST_OK; goff_in = '0; gbytes_in = '0;
               found_in = 1'b0; idx_in = '0;
               need_in = ({1'b0, req_request_size} + 17'd31) & ~17'd15;
               blk_in = req_payload_offset - 16'(HDR_BYTES);
               if (req_opcode == OP_ALLOC) begin
                  state_in = S_SRCH;
               end else if (req_payload_offset < 16'(HDR_BYTES)) begin
                  st_in = ST_NULL; state_in = S_STAT;
               end else if (count_ff >= CNT_MAX) begin
                  st_in = ST_FULL; state_in = S_STAT;
               end else begin
                  idx_in = count_ff; state_in = S_FRRD;
               end
               if (state_in == S_STAT) begin
                  total_in = '0; large_in = '0;
               end
            end
         end
         S_SRCH: begin
            // Compare the entry read last cycle; issue the next read.
            if (rdv_ff && rd_size >= need_ff && (!found_ff || rd_size < bent_ff[16:0])) begin
               found_in = 1'b1; best_in = EAW'(idx_ff - CW'(1)); bent_in = rd_ff;
            end
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + CW'(1); rdv_in = 1'b1;
            end else begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (!found_ff) begin
               st_in = ST_NOFIT; idx_in = '0; total_in = '0; large_in = '0;
               state_in = S_STAT;
            end else begin
               sw_en = 1'b1; s_waddr = SAW'(bent_ff[32:17] >> 4);
               goff_in = bent_ff[32:17] + 16'(HDR_BYTES);
               if ({1'b0, bent_ff[16:0]} >= {1'b0, need_ff} + 18'd32) begin
                  s_wdata = need_ff; gbytes_in = need_ff;
                  tw_en = 1'b1; tw_addr = best_ff;
                  tw_data = {bent_ff[32:17] + need_ff[15:0], bent_ff[16:0] - need_ff};
                  idx_in = '0; total_in = '0; large_in = '0; state_in = S_STAT;
               end else begin
                  s_wdata = bent_ff[16:0]; gbytes_in = bent_ff[16:0];
                  idx_in = CW'(best_ff) + CW'(1); state_in = S_RMRD;
               end
            end
         end
         S_RMRD: begin
            if (idx_ff < count_ff) begin
               state_in = S_RMWR;
            end else begin
               count_in = count_ff - CW'(1); idx_in = '0;
               total_in = '0; large_in = '0; state_in = S_STAT;
            end
         end
         S_RMWR: begin
            tw_en = 1'b1; tw_addr = EAW'(idx_ff - CW'(1)); tw_data = rd_ff;
            idx_in = idx_ff + CW'(1); state_in = S_RMRD;
         end
         S_FRRD: begin
            // idx is the destination; read its predecessor.
            if (idx_ff == '0) begin
               state_in = S_FRHD;
            end else begin
               tr_addr = EAW'(idx_ff - CW'(1)); state_in = S_FRWR;
            end
         end
         S_FRWR: begin
            tw_en = 1'b1; tw_addr = EAW'(idx_ff); tw_data = rd_ff;
            idx_in = idx_ff - CW'(1); state_in = S_FRRD;
         end
         S_FRHD: begin
            tw_en = 1'b1; tw_addr = '0; tw_data = {blk_ff, s_rdata};
            count_in = count_ff + CW'(1); idx_in = '0;
            total_in = '0; large_in = '0; state_in = S_STAT;
         end
         S_STAT: begin
            if (rdv_ff) begin
               total_in = sum_tw;
               if (rd_size > large_ff) large_in = rd_size;
            end
            if (idx_ff < count_ff) begin
               idx_in = idx_ff + CW'(1); rdv_in = 1'b1;
            end else begin
               state_in = S_RSP;
            end
         end
         S_RSP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; region_ff <= HI17; count_ff <= CW'(1);
         init_ff <= 1'b1; rdv_ff <= 1'b0; idx_ff <= '0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; region_ff <= region_in; count_ff <= count_in;
         init_ff <= init_in; rdv_ff <= rdv_in; idx_ff <= idx_in;
         found_ff <= found_in;
      end
      need_ff <= need_in; best_ff <= best_in; bent_ff <= bent_in;
      total_ff <= total_in; large_ff <= large_in; st_ff <= st_in;
      goff_ff <= goff_in; gbytes_ff <= gbytes_in; blk_ff <= blk_in;
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX) else $error("free count beyond table");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_ready) else $error("ready while busy");
   a_large_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (TW'(large_ff) <= total_ff)) else $error("largest above total");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && st_ff != ST_OK) |-> (goff_ff == '0 && gbytes_ff == '0))
      else $error("grant on failure");
`endif
endmodule

FILE: verif/best_fit_free_list_allocator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for best_fit_free_list_allocator_core: directed and random
// allocate/free traffic with a cycle-independent predictor. Depends on bfa_pkg and the RTL.
module best_fit_free_list_allocator_core_tb;
   import bfa_pkg::*;

   localparam int NUM_ENTRIES = 64;
   localparam int NUM_SLOTS   = 4096;
   localparam int DRAIN_WAIT  = 200;

   typedef struct {
      opcode_type  op;
      logic [15:0] rq;
      logic [15:0] pay;
   } alloc_req_type;

   typedef struct {
      status_type  st;
      logic [15:0] offset;
      logic [16:0] bytes;
      logic [16:0] total;
      logic [16:0] frag;
   } alloc_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_opcode = 1'b0;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_payload_offset = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_granted_offset;
   logic [16:0] rsp_granted_bytes;
   logic [16:0] rsp_free_total;
   logic [16:0] rsp_fragmented_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [16:0] csr_region_bytes = '0;

   always #4 clock = ~clock;

   best_fit_free_list_allocator_core dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_opcode, .req_request_size, .req_payload_offset,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_granted_offset, .rsp_granted_bytes,
      .rsp_free_total, .rsp_fragmented_bytes,
      .csr_valid, .csr_ready, .csr_region_bytes
   );

   // Shadow copy of the allocator: the free table, the per-slot size store and the
   // region size. It is advanced once per accepted request transfer.
   logic [15:0]  fl_off[NUM_ENTRIES];
   logic [16:0]  fl_size[NUM_ENTRIES];
   int           fl_count;
   logic [16:0]  slot_bytes[NUM_SLOTS];
   bit           slot_used[NUM_SLOTS];
   int           used_slots[$];
   logic [15:0]  live_pay[$];
   int unsigned  region;

   alloc_req_type pend_q[$];
   alloc_rsp_type expected_rsp[$];
   alloc_req_type cur;
   int           errors = 0;
   bit           calm = 1'b0;
   int           req_gap = 0;
   int           rsp_gap = 0;

   // Writing the region register rebuilds the table as one free block.
   task automatic rebuild_table(input int unsigned v);
      region = (v < 32) ? 32 : ((v > 65536) ? 65536 : v);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         fl_off[i] = '0;
         fl_size[i] = '0;
      end
      fl_size[0] = region[16:0];
      fl_count = 1;
      live_pay.delete();
   endtask

   task automatic predict_op(input alloc_req_type it);
      alloc_rsp_type r;
      int unsigned need, bsize, boff, total, largest, slot;
      int          best;
      bit          found;
      r = '{ST_OK, 16'd0, 17'd0, 17'd0, 17'd0};
      best = 0;
      found = 1'b0;
      if (it.op == OP_ALLOC) begin
         need = (int'(it.rq) + 16 + 15) & ~32'hF;
         for (int i = 0; i < fl_count; i++) begin
            if (fl_size[i] >= need && (!found || fl_size[i] < fl_size[best])) begin
               best = i;
               found = 1'b1;
            end
         end
         if (!found) begin
            r.st = ST_NOFIT;
         end else begin
            bsize = fl_size[best];
            boff = fl_off[best];
            // Split only when the remainder can hold a header and some payload.
            if (bsize >= need + 32) begin
               fl_off[best] = 16'((boff + need) & 32'hFFFF);
               fl_size[best] = 17'(bsize - need);
               bsize = need;
            end else begin
               for (int i = best; i + 1 < fl_count; i++) begin
                  fl_off[i] = fl_off[i + 1];
                  fl_size[i] = fl_size[i + 1];
               end
               fl_count--;
            end
            slot = (boff >> 4) % NUM_SLOTS;
            slot_bytes[slot] = 17'(bsize);
            if (!slot_used[slot]) begin
               slot_used[slot] = 1'b1;
               used_slots.push_back(slot);
            end
            r.offset = 16'((boff + 16) & 32'hFFFF);
            r.bytes = 17'(bsize);
            live_pay.push_back(r.offset);
         end
      end else if (it.pay < 16) begin
         r.st = ST_NULL;
      end else if (fl_count >= NUM_ENTRIES) begin
         r.st = ST_FULL;
      end else begin
         for (int i = fl_count; i > 0; i--) begin
            fl_off[i] = fl_off[i - 1];
            fl_size[i] = fl_size[i - 1];
         end
         fl_off[0] = it.pay - 16'd16;
         fl_size[0] = slot_bytes[(int'(it.pay) - 16) >> 4];
         fl_count++;
      end
      total = 0;
      largest = 0;
      for (int i = 0; i < fl_count; i++) begin
         total += fl_size[i];
         if (fl_size[i] > largest) largest = fl_size[i];
      end
      // Double frees can push the sums beyond 17 bits, so they saturate.
      r.total = (total > 131071) ? SAT17 : 17'(total);
      r.frag = (total - largest > 131071) ? SAT17 : 17'(total - largest);
      expected_rsp.push_back(r);
   endtask

   // Mostly short gaps, a few long ones, none at all during calm stretches.
   function automatic int draw_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Request driver: holds valid and payload steady until the transfer, then either
   // presents the next pending request at once or drops valid for a gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         predict_op(cur);
         req_gap = draw_gap();
         if (req_gap == 0 && pend_q.size() != 0) begin
            cur = pend_q.pop_front();
            req_opcode <= cur.op;
            req_request_size <= cur.rq;
            req_payload_offset <= cur.pay;
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pend_q.size() != 0) begin
            cur = pend_q.pop_front();
            req_valid <= 1'b1;
            req_opcode <= cur.op;
            req_request_size <= cur.rq;
            req_payload_offset <= cur.pay;
         end
      end
   end

   task automatic check_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   // Response monitor: compares every response transfer with the oldest prediction
   // and stalls rsp_ready at random.
   always @(posedge clock) begin
      alloc_rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected, status %0d", $time,
                        rsp_status);
            end else begin
               e = expected_rsp.pop_front();
               check_field("status", e.st, rsp_status);
               check_field("granted_offset", e.offset, rsp_granted_offset);
               check_field("granted_bytes", e.bytes, rsp_granted_bytes);
               check_field("free_total", e.total, rsp_free_total);
               check_field("fragmented_bytes", e.frag, rsp_fragmented_bytes);
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_gap = draw_gap();
         end
      end
   end

   // Queues one request and waits until it has been transferred, so the predictor
   // state is current when the next free target is chosen.
   task automatic send(input opcode_type op, input logic [15:0] rq,
                       input logic [15:0] pay);
      pend_q.push_back('{op, rq, pay});
      do @(posedge clock); while (pend_q.size() != 0 || req_valid);
   endtask

   task automatic drain();
      while (expected_rsp.size() != 0 || pend_q.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   // The region register is only written with the block idle; the extra wait adds margin
   // after the last response. Ready is sampled at
   // the edge itself, so valid drops right after the one transfer.
   task automatic write_region(input logic [16:0] v);
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_region_bytes <= v;
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
      rebuild_table(v);
   endtask

   // Free targets other than null frees map back to a slot that some allocate has written. Most are
   // live payloads; the rest are double frees, misaligned payloads or null frees.
   task automatic random_free();
      int          r, s, k;
      logic [15:0] p;
      r = $urandom_range(0, 99);
      if (r < 65 && live_pay.size() != 0) begin
         k = $urandom_range(0, live_pay.size() - 1);
         p = live_pay[k];
         live_pay.delete(k);
      end else if (r < 90 && used_slots.size() != 0) begin
         s = used_slots[$urandom_range(0, used_slots.size() - 1)];
         k = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : 0;
         p = 16'((s * 16 + k + 16) & 32'hFFFF);
      end else begin
         p = 16'($urandom_range(0, 15));
      end
      send(OP_FREE, 16'($urandom()), p);
   endtask

   task automatic random_alloc();
      int          r;
      logic [15:0] q;
      r = $urandom_range(0, 99);
      if (r < 70) q = 16'($urandom_range(0, 255));
      else if (r < 92) q = 16'($urandom_range(256, 4095));
      else q = 16'($urandom());
      send(OP_ALLOC, q, 16'($urandom()));
   endtask

   initial begin
      logic [16:0] regions[8];
      logic [15:0] p;
      regions = '{17'd65536, 17'd32, 17'd1000, 17'd131071, 17'd0, 17'd4096,
                  17'd300, 17'd65535};
      rebuild_table(65536);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: size extremes, exact fit, null and misaligned frees.
      send(OP_ALLOC, 16'd0, 16'hFFFF);
      send(OP_ALLOC, 16'hFFFF, 16'h0000);
      send(OP_ALLOC, 16'd16, 16'h1234);
      p = live_pay[$];
      send(OP_FREE, 16'hFFFF, p);
      send(OP_FREE, 16'd0, 16'd0);
      send(OP_FREE, 16'd0, 16'd15);
      send(OP_FREE, 16'd0, 16'd16);
      send(OP_FREE, 16'd0, p + 16'd5);
      send(OP_ALLOC, 16'd32, 16'd0);
      send(OP_ALLOC, 16'd40000, 16'd0);
      p = live_pay[$];
      // Freeing the same large block three times drives the total past 17 bits.
      repeat (3) send(OP_FREE, 16'd0, p);
      send(OP_ALLOC, 16'd65535, 16'd0);

      // Tiny region: a whole-block grant empties the table, then nothing fits.
      write_region(17'd32);
      send(OP_ALLOC, 16'd0, 16'd0);
      send(OP_ALLOC, 16'd0, 16'd0);
      send(OP_FREE, 16'd0, 16'd16);
      send(OP_ALLOC, 16'd1, 16'd0);

      // Random phases, one per region setting; the first and one later phase run
      // without random gaps so the table sees back-to-back traffic.
      for (int ph = 0; ph < 8; ph++) begin
         write_region(regions[ph]);
         calm = (ph == 0 || ph == 5);
         for (int n = 0; n < 178; n++) begin
            // Every so often the sender holds off until all responses are in.
            if (n % 60 == 59) drain();
            if ($urandom_range(0, 99) < 55) random_alloc();
            else random_free();
         end
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
